/* src/plc_pkg.sv */
// Package: shared types and constants for the polyline centroid block.
`timescale 1ns / 1ps
`default_nettype none
package plc_pkg;
   localparam int MaxPointsDefault = 1024;
   localparam int CoordBitsDefault = 16;
   localparam int FieldBits = 16;
   localparam int FifoDepth = 2;

   // one vertex as handed from the front to the back
   typedef struct packed {
      logic [FieldBits-1:0] point_x;
      logic [FieldBits-1:0] point_y;
      logic                 last_point;
   } vertex_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_ROOT,
      ST_MULT,
      ST_DIV,
      ST_OUT
   } state_type;
endpackage
`default_nettype wire

/* src/plc_front.sv */
// Front end: vertex queue between the input port and the segment engine.
`timescale 1ns / 1ps
`default_nettype none
module plc_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   output logic                 full,
   input  wire plc_pkg::vertex_type push_data,
   output logic                 q_valid,
   input  wire                  q_pop,
   output plc_pkg::vertex_type  q_data
);
   import plc_pkg::*;

   vertex_type mem_ff [FifoDepth];
   logic rd_ff, rd_in, wr_ff, wr_in;
   logic [1:0] cnt_ff, cnt_in;
   logic do_push, do_pop;

   assign full     = (cnt_ff == 2'(FifoDepth));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_data   = mem_ff[rd_ff];
   assign do_push  = push && !full;
   assign do_pop   = q_pop && q_valid;

   always_comb begin
      rd_in  = rd_ff ^ do_pop;
      wr_in  = wr_ff ^ do_push;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_ff  <= 1'b0;
         wr_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         rd_ff  <= rd_in;
         wr_ff  <= wr_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= 2'(FifoDepth)) else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |=> cnt_ff <= 2'd1) else $error("pop from empty queue");
   a_full_push: assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> full) else $error("full queue lost an entry");
endmodule
`default_nettype wire

/* src/plc_back.sv */
// Back end: segment length, weighted sums, and final division per polyline.
`timescale 1ns / 1ps
`default_nettype none
module plc_back #(
   parameter int MAX_POINTS = plc_pkg::MaxPointsDefault,
   parameter int COORD_BITS = plc_pkg::CoordBitsDefault
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  q_valid,
   output logic                 q_pop,
   input  wire plc_pkg::vertex_type q_data,
   output logic                 out_valid,
   input  wire                  out_taken,
   output logic [15:0]          rsp_centroid_x,
   output logic [15:0]          rsp_centroid_y,
   output logic                 rsp_zero_length,
   output logic                 rsp_count_overflow
);
   import plc_pkg::*;

   localparam int CB   = (COORD_BITS > 16) ? 17 : COORD_BITS;   // signed coord width
   localparam int DB   = CB + 1;                                 // difference width
   localparam int SQB  = 2 * DB;                                 // squared sum width
   localparam int RB   = DB + 1;                                 // root width
   localparam int RSTEP = SQB / 2;
   localparam int CNTB = $clog2(MAX_POINTS + 1);
   localparam int SB   = CB + 1 + RB + CNTB;                     // sum width
   localparam int TB   = RB + CNTB + 1;                          // 2*total width
   localparam int QB   = SB;
   localparam int SCB  = $clog2(SQB + 1);
   localparam int DCB  = $clog2(QB + 1);

   state_type state_ff, state_in;

   logic signed [CB-1:0] px_ff, py_ff, cx_ff, cy_ff;
   logic [CNTB-1:0] count_ff;
   logic signed [SB-1:0] sx_ff, sy_ff;
   logic [TB-1:0] total_ff;
   logic ovf_ff, last_ff;
   logic [SQB-1:0] rem_ff;
   logic [RB-1:0]  root_ff;
   logic [SCB-1:0] step_ff;
   // divider
   logic [QB-1:0] qx_ff, qy_ff;
   logic [TB:0]   rx_ff, ry_ff;
   logic [DCB-1:0] dstep_ff;
   logic [15:0] ox_ff, oy_ff;
   logic oz_ff, oo_ff, ov_ff;

   logic signed [CB-1:0] in_x, in_y;
   logic signed [DB-1:0] dx, dy;
   logic [SQB-1:0] sq;
   logic [QB-1:0] mx, my;
   logic [TB:0] tx, ty;
   logic [15:0] sat_x, sat_y;

   // wider coordinate settings take the 16-bit field as non-negative
   function automatic logic signed [CB-1:0] coord_of(input logic [15:0] raw);
      logic [CB-1:0] v;
      begin
         v = CB'(raw);
         return $signed(v);
      end
   endfunction

   function automatic logic [15:0] sat16(input logic [QB-1:0] q, input logic neg);
      begin
         if (neg) begin
            if (q > QB'(32768)) return 16'h8000;
            return 16'(-q);
         end
         if (q > QB'(32767)) return 16'h7fff;
         return q[15:0];
      end
   endfunction

   assign in_x = coord_of(q_data.point_x);
   assign in_y = coord_of(q_data.point_y);
   assign dx = DB'(cx_ff) - DB'(px_ff);
   assign dy = DB'(cy_ff) - DB'(py_ff);
   assign sq = SQB'(dx * dx) + SQB'(dy * dy);
   assign mx = sx_ff[SB-1] ? QB'(-sx_ff) : QB'(sx_ff);
   assign my = sy_ff[SB-1] ? QB'(-sy_ff) : QB'(sy_ff);
   assign tx = {rx_ff[TB-1:0], qx_ff[QB-1]};
   assign ty = {ry_ff[TB-1:0], qy_ff[QB-1]};
   assign sat_x = sat16(qx_ff, sx_ff[SB-1]);
   assign sat_y = sat16(qy_ff, sy_ff[SB-1]);

   assign out_valid          = ov_ff;
   assign rsp_centroid_x     = ox_ff;
   assign rsp_centroid_y     = oy_ff;
   assign rsp_zero_length    = oz_ff;
   assign rsp_count_overflow = oo_ff;

   // root work registers: remainder accumulator in its own register
   logic [RB+1:0] racc_ff;
   logic [RB+1:0] racc_sh, rtry;
   assign racc_sh = {racc_ff[RB-1:0], rem_ff[SQB-1 -: 2]};
   assign rtry    = racc_sh - {root_ff, 2'b01};

   logic accept, out_load;
   assign accept   = (state_ff == ST_IDLE) && q_valid;
   // result register loads once the previous result has been taken
   assign out_load = (state_ff == ST_OUT) && (!ov_ff || out_taken);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) begin
            if (count_ff >= CNTB'(MAX_POINTS) || count_ff == '0)
               state_in = q_data.last_point ? ST_DIV : ST_IDLE;
            else
               state_in = ST_ROOT;
         end
         ST_ROOT: if (step_ff == SCB'(RSTEP)) state_in = ST_MULT;
         ST_MULT: state_in = last_ff ? ST_DIV : ST_IDLE;
         ST_DIV:  if (dstep_ff == DCB'(QB)) state_in = ST_OUT;
         ST_OUT:  if (out_load) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      q_pop = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ov_ff    <= 1'b0;
         count_ff <= '0;
         sx_ff <= '0; sy_ff <= '0; total_ff <= '0; ovf_ff <= 1'b0;
         px_ff <= '0; py_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (out_load) ov_ff <= 1'b1;
         else if (out_taken) ov_ff <= 1'b0;
         case (state_ff)
            ST_IDLE: if (accept) begin
               last_ff <= q_data.last_point;
               if (count_ff >= CNTB'(MAX_POINTS)) begin
                  ovf_ff <= 1'b1;
               end else begin
                  count_ff <= count_ff + 1'b1;
                  cx_ff <= in_x; cy_ff <= in_y;
                  if (count_ff == '0) begin
                     px_ff <= in_x; py_ff <= in_y;
                  end
               end
               step_ff <= '0; root_ff <= '0; racc_ff <= '0;
               rem_ff  <= sq;
               dstep_ff <= '0;
            end
            ST_ROOT: begin
               if (step_ff == '0) rem_ff <= sq;
               else rem_ff <= rem_ff << 2;
               if (step_ff != '0) begin
                  if (!rtry[RB+1]) begin
                     racc_ff <= rtry;
                     root_ff <= {root_ff[RB-2:0], 1'b1};
                  end else begin
                     racc_ff <= racc_sh;
                     root_ff <= {root_ff[RB-2:0], 1'b0};
                  end
               end
               step_ff <= step_ff + 1'b1;
            end
            ST_MULT: begin
               sx_ff <= sx_ff + SB'((($signed({px_ff[CB-1], px_ff}) +
                        $signed({cx_ff[CB-1], cx_ff}))) * $signed({1'b0, root_ff}));
               sy_ff <= sy_ff + SB'((($signed({py_ff[CB-1], py_ff}) +
                        $signed({cy_ff[CB-1], cy_ff}))) * $signed({1'b0, root_ff}));
               total_ff <= total_ff + TB'({root_ff, 1'b0});
               px_ff <= cx_ff; py_ff <= cy_ff;
               dstep_ff <= '0;
            end
            ST_DIV: begin
               if (dstep_ff == '0) begin
                  qx_ff <= mx; qy_ff <= my; rx_ff <= '0; ry_ff <= '0;
               end else begin
                  if (tx >= {1'b0, total_ff}) begin
                     rx_ff <= tx - {1'b0, total_ff};
                     qx_ff <= {qx_ff[QB-2:0], 1'b1};
                  end else begin
                     rx_ff <= tx; qx_ff <= {qx_ff[QB-2:0], 1'b0};
                  end
                  if (ty >= {1'b0, total_ff}) begin
                     ry_ff <= ty - {1'b0, total_ff};
                     qy_ff <= {qy_ff[QB-2:0], 1'b1};
                  end else begin
                     ry_ff <= ty; qy_ff <= {qy_ff[QB-2:0], 1'b0};
                  end
               end
               dstep_ff <= dstep_ff + 1'b1;
            end
            ST_OUT: if (out_load) begin
               oo_ff <= ovf_ff;
               if (count_ff <= CNTB'(1)) begin
                  ox_ff <= 16'(px_ff); oy_ff <= 16'(py_ff); oz_ff <= 1'b0;
               end else if (total_ff == '0) begin
                  ox_ff <= '0; oy_ff <= '0; oz_ff <= 1'b1;
               end else begin
                  ox_ff <= sat_x; oy_ff <= sat_y; oz_ff <= 1'b0;
               end
               count_ff <= '0; sx_ff <= '0; sy_ff <= '0; total_ff <= '0;
               ovf_ff <= 1'b0; px_ff <= '0; py_ff <= '0;
            end
            default: ;
         endcase
      end
   end

   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> state_ff == ST_IDLE) else $error("pop outside idle");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (ov_ff && !out_taken) |=> ov_ff && $stable(ox_ff))
      else $error("result changed while stalled");
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNTB'(MAX_POINTS)) else $error("vertex count past bound");
endmodule
`default_nettype wire

/* src/polyline_length_weighted_centroid.sv */
// Top level: length-weighted polyline centroid with queue-style ports.
//
// Usage: push one vertex (req_point_x, req_point_y, req_last_point) per
// transaction while full is low. Each segment between consecutive vertices
// is measured with a bit-serial square root followed by a multiply-accumulate
// step. A last vertex additionally runs a restoring divider of one quotient
// bit per cycle over the sum width and then posts one result.
// Results: while empty is low, rsp_* hold the centroid; pop takes the
// transaction. A small vertex queue decouples the input from the engine,
// so pushes are taken while the engine works or while a result waits.
// When the receiver stalls, the finished result is held in the output
// register and the engine keeps working on the next polyline until it has
// its own result to post; it waits there, and the queue then fills and
// raises full.
// Reset (synchronous, active high) empties the queue, drops any pending
// result and clears all sums.
`timescale 1ns / 1ps
`default_nettype none
module polyline_length_weighted_centroid #(
   parameter int MAX_POINTS = plc_pkg::MaxPointsDefault,
   parameter int COORD_BITS = plc_pkg::CoordBitsDefault
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         push,
   output logic        full,
   input  wire  [15:0] req_point_x,
   input  wire  [15:0] req_point_y,
   input  wire         req_last_point,
   output logic        empty,
   input  wire         pop,
   output logic [15:0] rsp_centroid_x,
   output logic [15:0] rsp_centroid_y,
   output logic        rsp_zero_length,
   output logic        rsp_count_overflow
);
   import plc_pkg::*;

   vertex_type push_data, q_data;
   logic q_valid, q_pop, out_valid;

   assign push_data = '{point_x: req_point_x, point_y: req_point_y,
                        last_point: req_last_point};
   assign empty = !out_valid;

   plc_front u_front (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .push_data(push_data), .q_valid(q_valid), .q_pop(q_pop), .q_data(q_data)
   );

   plc_back #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_pop(q_pop),
      .q_data(q_data), .out_valid(out_valid), .out_taken(pop),
      .rsp_centroid_x(rsp_centroid_x), .rsp_centroid_y(rsp_centroid_y),
      .rsp_zero_length(rsp_zero_length), .rsp_count_overflow(rsp_count_overflow)
   );
endmodule
`default_nettype wire
